// ===== rtl/core/lzwe_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwe_pkg
// Constants shared by the variable-width LZW encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwe_pkg;

    // First learned dictionary code; codes 1..256 stand for single bytes.
    localparam int unsigned FIRST_CODE  = 257;
    // Code width after reset and after each end of stream.
    localparam int unsigned START_WIDTH = 9;
    // Escape code, sent before the code width grows.
    localparam int unsigned ESC_CODE    = 0;
    // Bits that may remain pending between bytes.
    localparam int unsigned PEND_BITS   = 7;

endpackage : lzwe_pkg

`default_nettype wire

// ===== rtl/core/lzwe_ram.sv =====
// ----------------------------------------------------------------------------
// lzwe_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : lzwe_ram

`default_nettype wire

// ===== rtl/core/lzw_encoder_variable_width_top.sv =====
// ----------------------------------------------------------------------------
// lzw_encoder_variable_width_top
// Variable-width LZW encoder with a packed, MSB-first byte output stream.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one raw byte per word in tdata, tlast marks the
// final byte of a stream. Output channel (m_axis): one byte of packed code
// bits per word, tlast on the final byte of the compressed stream.
// The dictionary is a trie kept in two RAMs indexed by code: a head RAM
// holding the newest child of each code and an entry RAM holding prefix,
// suffix and the next older sibling. The block takes one word at a time.
// A word passes through an accept, a head read and a walk over the siblings
// of the current code. A miss then emits the code (at most two output bytes
// per code), a width escape emits the escape code, and an end of stream
// emits the last code and pads out the final byte if bits remain. The first
// byte of a stream needs no dictionary lookup; the worst-case walk is 256
// siblings.
// Reset returns the code counter, width and bit packer to their start values
// and clears all 2^MAX_BITS head RAM entries (4096), during which no word
// is taken. Stale entries from earlier streams are range-checked against the
// code counter. The output byte sits in a register; while the receiver
// stalls, the block holds its next byte and takes no input until it is out.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_encoder_variable_width_top
    import lzwe_pkg::*;
#(
    parameter int unsigned MAX_BITS = 12
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire        s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // out_last
);

    localparam int unsigned MB    = MAX_BITS;
    localparam int unsigned NB    = MAX_BITS + 1;
    localparam int unsigned DEPTH = 1 << MAX_BITS;
    localparam int unsigned AW    = PEND_BITS + MAX_BITS;
    localparam int unsigned WW    = $clog2(MAX_BITS + 1);
    localparam int unsigned CB    = $clog2(AW + 1);
    localparam int unsigned EW    = 2 * MAX_BITS + 8;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HEAD, S_ENT, S_OUT, S_GROW, S_NEW, S_FIN, S_PAD
    } t_state;

    typedef enum logic [1:0] {
        RET_GROW, RET_NEW, RET_PAD
    } t_ret;

    t_state        r_state;
    t_ret          r_ret;
    logic [MB-1:0] r_clr;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [MB-1:0] r_cur;
    logic [MB-1:0] r_node;
    logic [MB-1:0] r_head;
    logic [NB-1:0] r_next;
    logic [WW-1:0] r_width;
    logic [AW-1:0] r_acc;
    logic [CB-1:0] r_cnt;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;

    // RAM ports.
    logic          head_we;
    logic [MB-1:0] head_waddr;
    logic [MB-1:0] head_wdata;
    logic [MB-1:0] head_raddr;
    logic [MB-1:0] head_rdata;
    logic          ent_we;
    logic [MB-1:0] ent_waddr;
    logic [EW-1:0] ent_wdata;
    logic [MB-1:0] ent_raddr;
    logic [EW-1:0] ent_rdata;

    logic [MB-1:0] ent_prefix;
    logic [7:0]    ent_suffix;
    logic [MB-1:0] ent_sib;
    logic [NB-1:0] width_lim;
    logic          room;
    logic          grow;
    logic          head_ok;
    logic          sib_ok;
    logic          hit;
    logic          miss;
    logic          out_free;
    logic          out_load;
    logic [CB-1:0] cnt_sub;
    logic [MB-1:0] byte_code;

    assign ent_prefix = ent_rdata[MB-1:0];
    assign ent_suffix = ent_rdata[MB+7:MB];
    assign ent_sib    = ent_rdata[EW-1:MB+8];
    assign byte_code  = MB'(r_byte) + MB'(1);
    assign width_lim  = NB'(1) << r_width;
    assign room       = r_next < width_lim;
    assign grow       = !room && (r_width < WW'(MB));
    assign head_ok    = (NB'(head_rdata) >= NB'(FIRST_CODE)) && (NB'(head_rdata) < r_next);
    assign sib_ok     = (ent_sib >= MB'(FIRST_CODE)) && (ent_sib < r_node);
    assign hit        = (r_state == S_ENT) && (ent_prefix == r_cur) && (ent_suffix == r_byte);
    // A chain ends at a pointer out of range or at a stale node of another prefix.
    assign miss       = ((r_state == S_HEAD) && !head_ok) ||
                        ((r_state == S_ENT) && !hit &&
                         ((ent_prefix != r_cur) || !sib_ok));
    assign out_free   = !r_ovalid || m_axis_tready;
    assign out_load   = out_free && (((r_state == S_OUT) && (r_cnt >= CB'(8))) ||
                                     ((r_state == S_PAD) && (r_cnt != '0)));
    assign cnt_sub    = r_cnt - CB'(8);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_obyte;
    assign m_axis_tlast  = r_olast;

    always_comb begin
        head_raddr = r_cur;
        ent_raddr  = (r_state == S_HEAD) ? head_rdata : ent_sib;
        head_we    = (r_state == S_CLR) || (miss && room);
        head_waddr = (r_state == S_CLR) ? r_clr : r_cur;
        head_wdata = (r_state == S_CLR) ? '0 : r_next[MB-1:0];
        ent_we     = miss && room;
        ent_waddr  = r_next[MB-1:0];
        // Sibling of a new entry is the head read for this lookup.
        ent_wdata  = {((r_state == S_HEAD) ? head_rdata : r_head), r_byte, r_cur};
    end

    lzwe_ram #(.WIDTH(MB), .DEPTH(DEPTH)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    lzwe_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ret    <= RET_NEW;
            r_clr    <= '0;
            r_cur    <= '0;
            r_next   <= NB'(FIRST_CODE);
            r_width  <= WW'(START_WIDTH);
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + MB'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_byte <= s_axis_tdata;
                        r_last <= s_axis_tlast;
                        if (r_cur == '0) begin
                            r_cur   <= MB'(s_axis_tdata) + MB'(1);
                            r_state <= s_axis_tlast ? S_FIN : S_IDLE;
                        end else begin
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD, S_ENT: begin
                    if (r_state == S_HEAD) begin
                        r_head <= head_rdata;
                        r_node <= head_rdata;
                    end else begin
                        r_node <= ent_sib;
                    end
                    if (hit) begin
                        r_cur   <= r_node;
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end else if (miss) begin
                        r_acc   <= AW'(r_acc << r_width) | AW'(r_cur);
                        r_cnt   <= r_cnt + CB'(r_width);
                        r_ret   <= RET_GROW;
                        r_state <= S_OUT;
                        if (room) begin
                            r_next <= r_next + NB'(1);
                        end
                    end else begin
                        r_state <= S_ENT;
                    end
                end
                S_OUT: begin
                    if (r_cnt < CB'(8)) begin
                        case (r_ret)
                            RET_GROW: r_state <= S_GROW;
                            RET_NEW:  r_state <= S_NEW;
                            RET_PAD:  r_state <= S_PAD;
                            default:  r_state <= S_NEW;
                        endcase
                    end else if (out_free) begin
                        r_obyte  <= 8'(r_acc >> cnt_sub);
                        r_olast  <= (r_ret == RET_PAD) && (cnt_sub == '0);
                        r_cnt    <= cnt_sub;
                    end
                end
                S_GROW: begin
                    if (grow) begin
                        r_acc   <= AW'(r_acc << r_width) | AW'(ESC_CODE);
                        r_cnt   <= r_cnt + CB'(r_width);
                        r_width <= r_width + WW'(1);
                        r_ret   <= RET_NEW;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_NEW;
                    end
                end
                S_NEW: begin
                    r_cur   <= byte_code;
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_acc   <= AW'(r_acc << r_width) | AW'(r_cur);
                    r_cnt   <= r_cnt + CB'(r_width);
                    r_ret   <= RET_PAD;
                    r_state <= S_OUT;
                end
                S_PAD: begin
                    if (r_cnt == '0 || out_free) begin
                        if (r_cnt != '0) begin
                            r_obyte  <= 8'(r_acc << (CB'(8) - r_cnt));
                            r_olast  <= 1'b1;
                        end
                        r_cur   <= '0;
                        r_next  <= NB'(FIRST_CODE);
                        r_width <= WW'(START_WIDTH);
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Between items, fewer than eight bits may stay pending.
    a_pending_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt < CB'(8)))
        else $error("pending bit count reached a full byte while idle");

    // A walked node is always a learned code below the code counter.
    a_node_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENT) |-> ((NB'(r_node) >= NB'(FIRST_CODE)) && (NB'(r_node) < r_next)))
        else $error("dictionary walk left the learned range");

    // The code width stays within its bounds and covers the code counter.
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_width >= WW'(START_WIDTH)) && (r_width <= WW'(MB)) && (r_next <= width_lim))
        else $error("code width out of range");

endmodule : lzw_encoder_variable_width_top

`default_nettype wire
